@@ sv/sva_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_pkg
// Shared sizes, item and result types and round-robin helpers for the
// separable VC allocator.
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int PORTS = 5;
  localparam int VCS   = 4;
  localparam int NOVC  = PORTS * VCS;

  // field widths of the ports
  localparam int FPW = 3;
  localparam int FVW = 2;
  localparam int FKW = 3;

  // internal index widths
  localparam int OW  = (NOVC > 1) ? $clog2(NOVC) : 1;
  localparam int PPW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int VPW = (VCS > 1) ? $clog2(VCS) : 1;

  typedef enum logic [FKW-1:0] {
    KIND_REQ = 3'd0,
    KIND_ARB = 3'd1,
    KIND_CLR = 3'd2,
    KIND_SQ  = 3'd3,
    KIND_QRY = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ARB,
    ST_SQ
  } state_e;

  // classified item between front and back
  typedef struct packed {
    kind_e           kind;
    logic [FPW-1:0]  op;
    logic            out_ok;
    logic            in_ok;
    logic [OW-1:0]   o;
    logic [OW-1:0]   w;
  } item_t;

  typedef struct packed {
    logic           acc;
    logic           err;
    logic           gv;
    logic [FPW-1:0] gop;
    logic [FVW-1:0] gov;
    logic [FPW-1:0] gip;
    logic [FVW-1:0] giv;
    logic           last;
  } result_t;

  // first set bit after last, wrapping over VCS
  function automatic logic [VPW-1:0] rr_vc(logic [VCS-1:0] bits, logic [VPW-1:0] last);
    int c;
    logic hit;
    logic [VPW-1:0] pick;
    hit  = 1'b0;
    pick = last;
    for (int j = 1; j <= VCS; j++) begin
      c = int'(last) + j;
      if (c >= VCS) c = c - VCS;
      if (!hit && bits[c]) begin
        hit  = 1'b1;
        pick = VPW'(c);
      end
    end
    return pick;
  endfunction

  // first set bit after last, wrapping over PORTS
  function automatic logic [PPW-1:0] rr_port(logic [PORTS-1:0] bits, logic [PPW-1:0] last);
    int c;
    logic hit;
    logic [PPW-1:0] pick;
    hit  = 1'b0;
    pick = last;
    for (int j = 1; j <= PORTS; j++) begin
      c = int'(last) + j;
      if (c >= PORTS) c = c - PORTS;
      if (!hit && bits[c]) begin
        hit  = 1'b1;
        pick = PPW'(c);
      end
    end
    return pick;
  endfunction

endpackage

@@ sv/sva_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_front
// Accepts items, range-checks and flattens the VC indexes, and queues the
// classified items in a two-entry buffer for the allocation engine.
// ----------------------------------------------------------------------------
module sva_front import sva_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [FKW-1:0] kind_i,
  input  logic [FPW-1:0] out_port_i,
  input  logic [FVW-1:0] out_vc_i,
  input  logic [FPW-1:0] in_port_i,
  input  logic [FVW-1:0] in_vc_i,
  output logic           item_valid_o,
  input  logic           item_ready_i,
  output item_t          item_o
);

  item_t       buf_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  item_t       cls;
  logic        push, pop;

  always_comb begin
    cls.kind   = kind_e'(kind_i);
    cls.op     = out_port_i;
    cls.out_ok = (int'(out_port_i) < PORTS) && (int'(out_vc_i) < VCS);
    cls.in_ok  = (int'(in_port_i) < PORTS) && (int'(in_vc_i) < VCS);
    cls.o      = OW'(int'(out_port_i) * VCS + int'(out_vc_i));
    cls.w      = OW'(int'(in_port_i) * VCS + int'(in_vc_i));
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = buf_q[rd_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = 2'(cnt_q + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= cls;
    end
  end

endmodule

@@ sv/sva_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_back
// Allocation engine: holds request, lock, winner and pointer state per
// output VC, and executes one queued item at a time, arbitrate and squash through a row scan.
// ----------------------------------------------------------------------------
module sva_back import sva_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  output logic    item_ready_o,
  input  item_t   item_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  logic [NOVC-1:0] req_q [NOVC];
  logic [NOVC-1:0] lock_q, wv_q;
  logic [OW-1:0]   win_q [NOVC];
  logic [PPW-1:0]  pp_q [NOVC];
  logic [VPW-1:0]  vp_q [NOVC][PORTS];

  state_e          state_q, state_d;
  item_t           cur_q, cur_d;
  logic [OW-1:0]   idx_q;
  logic [PPW-1:0]  port_q;
  logic [VPW-1:0]  vc_q;
  logic            found_q, found_d;
  logic            ov_q;
  result_t         res_q, res_d;

  logic            slot_free, emit, advance, start_arb, start_sq, done;
  logic [OW-1:0]   addr;
  logic [NOVC-1:0] row_any, later_mask;
  logic            any_pending, later;

  logic [NOVC-1:0] row_req, row_req_d;
  logic            row_lock, row_lock_d, row_wv, row_wv_d, row_we;
  logic [OW-1:0]   row_win, row_win_d;
  logic [PPW-1:0]  row_pp_d;
  logic [VPW-1:0]  row_vp_d [PORTS];

  logic [PORTS-1:0] port_any;
  logic [VPW-1:0]   nvp [PORTS];
  logic [PPW-1:0]   gp;
  logic [VPW-1:0]   gvc;
  logic             match, self_row;

  assign slot_free = !ov_q || res_ready_i;
  assign addr      = (state_q == ST_IDLE) ? item_i.o : idx_q;
  assign row_req   = req_q[addr];
  assign row_lock  = lock_q[addr];
  assign row_wv    = wv_q[addr];
  assign row_win   = win_q[addr];

  // rows that would grant on this arbitration pass
  always_comb begin
    for (int j = 0; j < NOVC; j++) begin
      row_any[j]    = !lock_q[j] && (|req_q[j]);
      later_mask[j] = (j > int'(idx_q));
    end
  end
  assign any_pending = |row_any;
  assign later       = |(row_any & later_mask);

  // two-stage separable pick on the addressed row
  always_comb begin
    for (int p = 0; p < PORTS; p++) begin
      port_any[p] = |row_req[p*VCS +: VCS];
      nvp[p]      = port_any[p] ? rr_vc(row_req[p*VCS +: VCS], vp_q[addr][p])
                                : vp_q[addr][p];
    end
    gp  = rr_port(port_any, pp_q[addr]);
    gvc = nvp[gp];
  end

  assign match    = row_wv && (row_win == cur_q.w);
  assign self_row = cur_q.out_ok && (idx_q == cur_q.o);

  always_comb begin
    row_we     = 1'b0;
    row_req_d  = row_req;
    row_lock_d = row_lock;
    row_wv_d   = row_wv;
    row_win_d  = row_win;
    row_pp_d   = pp_q[addr];
    for (int p = 0; p < PORTS; p++) row_vp_d[p] = vp_q[addr][p];
    item_ready_o = 1'b0;
    emit      = 1'b0;
    advance   = 1'b0;
    start_arb = 1'b0;
    start_sq  = 1'b0;
    done      = 1'b0;
    res_d     = '0;
    cur_d     = cur_q;
    found_d   = found_q;
    case (state_q)
      ST_IDLE: begin
        item_ready_o = slot_free;
        if (item_valid_i && slot_free) begin
          cur_d      = item_i;
          res_d.last = 1'b1;
          case (item_i.kind)
            KIND_REQ: begin
              emit = 1'b1;
              if (item_i.out_ok && item_i.in_ok && !row_lock) begin
                row_we               = 1'b1;
                row_req_d[item_i.w]  = 1'b1;
                res_d.acc            = 1'b1;
              end
            end
            KIND_ARB: begin
              if (any_pending) start_arb = 1'b1;
              else emit = 1'b1;
            end
            KIND_CLR: begin
              emit = 1'b1;
              if (item_i.out_ok && item_i.in_ok && row_wv && row_win == item_i.w) begin
                row_we              = 1'b1;
                row_req_d[item_i.w] = 1'b0;
                row_lock_d          = 1'b0;
                row_wv_d            = 1'b0;
                row_win_d           = '0;
              end else begin
                res_d.err = 1'b1;
              end
            end
            KIND_SQ: begin
              if (item_i.in_ok) begin
                start_sq = 1'b1;
                found_d  = item_i.out_ok && row_wv && (row_win == item_i.w);
              end else begin
                emit = 1'b1;
              end
            end
            KIND_QRY: begin
              emit      = 1'b1;
              res_d.acc = item_i.out_ok && item_i.in_ok && row_req[item_i.w];
            end
            default: emit = 1'b1;
          endcase
        end
      end
      ST_ARB: begin
        if (!row_any[idx_q]) begin
          advance = 1'b1;
          done    = (int'(idx_q) == NOVC - 1);
        end else if (slot_free) begin
          advance    = 1'b1;
          emit       = 1'b1;
          row_we     = 1'b1;
          row_lock_d = 1'b1;
          row_wv_d   = 1'b1;
          row_win_d  = OW'(int'(gp) * VCS + int'(gvc));
          row_pp_d   = gp;
          for (int p = 0; p < PORTS; p++) row_vp_d[p] = nvp[p];
          res_d.gv   = 1'b1;
          res_d.gop  = FPW'(port_q);
          res_d.gov  = FVW'(vc_q);
          res_d.gip  = FPW'(gp);
          res_d.giv  = FVW'(gvc);
          res_d.last = !later;
          done       = !later || (int'(idx_q) == NOVC - 1);
        end
      end
      ST_SQ: begin
        if ((int'(idx_q) != NOVC - 1) || slot_free) begin
          advance = 1'b1;
          if (match && !self_row) begin
            row_we               = 1'b1;
            row_req_d[cur_q.w]   = 1'b0;
            row_lock_d           = 1'b0;
            row_wv_d             = 1'b0;
            row_win_d            = '0;
          end else if (found_q && (int'(port_q) == int'(cur_q.op)) && !self_row) begin
            row_we               = 1'b1;
            row_req_d[cur_q.w]   = 1'b0;
          end
          if (int'(idx_q) == NOVC - 1) begin
            emit       = 1'b1;
            res_d.last = 1'b1;
            done       = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_arb) state_d = ST_ARB;
        else if (start_sq) state_d = ST_SQ;
      end
      ST_ARB, ST_SQ: begin
        if (done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      port_q  <= '0;
      vc_q    <= '0;
      found_q <= 1'b0;
      ov_q    <= 1'b0;
      lock_q  <= '0;
      wv_q    <= '0;
      for (int j = 0; j < NOVC; j++) begin
        req_q[j] <= '0;
        win_q[j] <= '0;
        pp_q[j]  <= '0;
        for (int p = 0; p < PORTS; p++) vp_q[j][p] <= '0;
      end
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      if (start_arb || start_sq) begin
        idx_q  <= '0;
        port_q <= '0;
        vc_q   <= '0;
      end else if (advance) begin
        idx_q <= OW'(int'(idx_q) + 1);
        if (int'(vc_q) == VCS - 1) begin
          vc_q   <= '0;
          port_q <= PPW'(int'(port_q) + 1);
        end else begin
          vc_q <= VPW'(int'(vc_q) + 1);
        end
      end
      if (emit) ov_q <= 1'b1;
      else if (res_ready_i) ov_q <= 1'b0;
      if (row_we) begin
        req_q[addr]  <= row_req_d;
        lock_q[addr] <= row_lock_d;
        wv_q[addr]   <= row_wv_d;
        win_q[addr]  <= row_win_d;
        pp_q[addr]   <= row_pp_d;
        for (int p = 0; p < PORTS; p++) vp_q[addr][p] <= row_vp_d[p];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) res_q <= res_d;
  end

  assign res_valid_o = ov_q;
  assign res_o       = res_q;

endmodule

@@ sv/separable_vc_allocator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_vc_allocator_top
// Input-first round-robin VC allocator: classifying front, two-entry item
// queue, and a row-scanning allocation engine with a registered result beat.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid_i / in_ready_o | kind, out_port, out_vc, in_port, in_vc
//  out     | out_valid_o/out_ready_i | accepted, error, grant_*, last
//
// Request, clear, query and unknown kinds are handled in the engine's idle
// state; the item passes the front queue, and its result beat is registered
// and held back while the previous beat is still pending and not being taken.
// Arbitrate and squash start from the idle state, then scan the output VC rows,
// one row a cycle while no beat waits for a free result slot: 20 rows for squash,
// up to 20 for arbitrate, set by the single-row state port of the engine.
// Arbitrate stops after the row of its last grant; a full output beat stalls it.
// Reset clears all allocator state at once; no clearing pass.
// ----------------------------------------------------------------------------
module separable_vc_allocator_top import sva_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [FKW-1:0] kind_i,
  input  logic [FPW-1:0] out_port_i,
  input  logic [FVW-1:0] out_vc_i,
  input  logic [FPW-1:0] in_port_i,
  input  logic [FVW-1:0] in_vc_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           accepted_o,
  output logic           error_o,
  output logic           grant_valid_o,
  output logic [FPW-1:0] grant_out_port_o,
  output logic [FVW-1:0] grant_out_vc_o,
  output logic [FPW-1:0] grant_in_port_o,
  output logic [FVW-1:0] grant_in_vc_o,
  output logic           last_o
);

  logic    item_valid, item_ready;
  item_t   item;
  result_t res;

  sva_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .out_port_i   (out_port_i),
    .out_vc_i     (out_vc_i),
    .in_port_i    (in_port_i),
    .in_vc_i      (in_vc_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  sva_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign accepted_o       = res.acc;
  assign error_o          = res.err;
  assign grant_valid_o    = res.gv;
  assign grant_out_port_o = res.gop;
  assign grant_out_vc_o   = res.gov;
  assign grant_in_port_o  = res.gip;
  assign grant_in_vc_o    = res.giv;
  assign last_o           = res.last;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Bench for the separable VC allocator. Directed tests cover each item kind,
// round-robin ordering, clear errors, squash and out-of-range indexes; a
// random phase then drives request/arbitrate/clear/squash/query traffic with noise.
// Each result beat is compared field by field with a local allocator model.
// ----------------------------------------------------------------------------
module testbench;
  import sva_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  logic [FKW-1:0] kind_i;
  logic [FPW-1:0] out_port_i;
  logic [FVW-1:0] out_vc_i;
  logic [FPW-1:0] in_port_i;
  logic [FVW-1:0] in_vc_i;
  logic           out_valid_o;
  logic           out_ready_i;
  logic           accepted_o;
  logic           error_o;
  logic           grant_valid_o;
  logic [FPW-1:0] grant_out_port_o;
  logic [FVW-1:0] grant_out_vc_o;
  logic [FPW-1:0] grant_in_port_o;
  logic [FVW-1:0] grant_in_vc_o;
  logic           last_o;

  separable_vc_allocator_top uut (.*);

  // allocator model state
  logic [NOVC-1:0] req_bits  [NOVC];
  logic            locked    [NOVC];
  logic            win_valid [NOVC];
  int              win_index [NOVC];
  int              port_ptr  [NOVC];
  int              vc_ptr    [NOVC][PORTS];

  result_t expected_beats[$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  bit      steady = 0;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic int rr_next(logic [7:0] bits, int count, int prev);
    int c;
    for (int j = 1; j <= count; j++) begin
      c = (prev + j) % count;
      if (bits[c]) return c;
    end
    return prev;
  endfunction

  function automatic void release_vc(int i, int w);
    req_bits[i][w] = 1'b0;
    locked[i]      = 1'b0;
    win_valid[i]   = 1'b0;
    win_index[i]   = 0;
  endfunction

  // advance model by one item and queue the beats it causes
  function automatic void alloc_predict(logic [2:0] kind, logic [2:0] op, logic [1:0] ov,
                                        logic [2:0] ip, logic [1:0] iv);
    result_t r;
    result_t beats[$];
    bit out_ok, in_ok, found;
    int o, w, gp, gvc;
    logic [7:0] b, any;
    out_ok = (op < PORTS) && (ov < VCS);
    in_ok  = (ip < PORTS) && (iv < VCS);
    o = int'(op) * VCS + int'(ov);
    w = int'(ip) * VCS + int'(iv);
    r = '0;
    case (kind)
      KIND_REQ: begin
        if (out_ok && in_ok && !locked[o]) begin
          req_bits[o][w] = 1'b1;
          r.acc = 1'b1;
        end
        beats.push_back(r);
      end
      KIND_ARB: begin
        for (int i = 0; i < NOVC; i++) begin
          if (locked[i]) continue;
          any = '0;
          for (int p = 0; p < PORTS; p++) begin
            b = 8'((req_bits[i] >> (p * VCS)) & ((1 << VCS) - 1));
            if (b != 0) begin
              vc_ptr[i][p] = rr_next(b, VCS, vc_ptr[i][p]);
              any[p] = 1'b1;
            end
          end
          if (any != 0) begin
            gp  = rr_next(any, PORTS, port_ptr[i]);
            gvc = vc_ptr[i][gp];
            port_ptr[i]  = gp;
            locked[i]    = 1'b1;
            win_valid[i] = 1'b1;
            win_index[i] = gp * VCS + gvc;
            r = '0;
            r.gv  = 1'b1;
            r.gop = FPW'(i / VCS);
            r.gov = FVW'(i % VCS);
            r.gip = FPW'(gp);
            r.giv = FVW'(gvc);
            beats.push_back(r);
          end
        end
        if (beats.size() == 0) beats.push_back('0);
      end
      KIND_CLR: begin
        r.err = 1'b1;
        if (out_ok && in_ok && win_valid[o] && win_index[o] == w) begin
          release_vc(o, w);
          r.err = 1'b0;
        end
        beats.push_back(r);
      end
      KIND_SQ: begin
        if (in_ok) begin
          found = 0;
          for (int i = 0; i < NOVC; i++)
            if (win_valid[i] && win_index[i] == w && !(out_ok && i == o))
              release_vc(i, w);
          if (op < PORTS) begin
            for (int i = op * VCS; i < op * VCS + VCS; i++)
              if (win_valid[i] && win_index[i] == w) found = 1;
            if (found)
              for (int i = op * VCS; i < op * VCS + VCS; i++)
                if (!(win_valid[i] && win_index[i] == w)) req_bits[i][w] = 1'b0;
          end
        end
        beats.push_back(r);
      end
      KIND_QRY: begin
        if (out_ok && in_ok) r.acc = req_bits[o][w];
        beats.push_back(r);
      end
      default: beats.push_back(r);
    endcase
    beats[beats.size() - 1].last = 1'b1;
    foreach (beats[k]) expected_beats.push_back(beats[k]);
  endfunction

  // send one item; valid stays high after the beat unless a gap follows
  task automatic send_item(logic [2:0] kind, logic [2:0] op, logic [1:0] ov,
                           logic [2:0] ip, logic [1:0] iv);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    gap = steady ? 0 : (roll < 60) ? 0 : (roll < 95) ? $urandom_range(1, 3)
                                                     : $urandom_range(10, 40);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i = kind; out_port_i = op; out_vc_i = ov; in_port_i = ip; in_vc_i = iv;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    alloc_predict(kind, op, ov, ip, iv);
  endtask

  task automatic send_random_noise();
    send_item(3'($urandom), 3'($urandom), 2'($urandom), 3'($urandom), 2'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
  endtask

  // pick a locked output VC and its winner, if any
  function automatic bit choose_locked_vc(output int o, output int w);
    int list[$];
    for (int i = 0; i < NOVC; i++) if (win_valid[i]) list.push_back(i);
    if (list.size() == 0) return 0;
    o = list[$urandom_range(0, list.size() - 1)];
    w = win_index[o];
    return 1;
  endfunction

  task automatic test_requests_and_grants();
    send_item(KIND_QRY, 0, 0, 0, 0);
    send_item(KIND_ARB, 0, 0, 0, 0);          // nothing requested
    send_item(KIND_REQ, 0, 0, 0, 0);
    send_item(KIND_REQ, 0, 0, 4, 3);
    send_item(KIND_REQ, 0, 0, 4, 1);
    send_item(KIND_REQ, 4, 3, 2, 2);
    send_item(KIND_QRY, 0, 0, 4, 3);
    send_item(KIND_ARB, 0, 0, 0, 0);
    send_item(KIND_REQ, 0, 0, 1, 1);          // locked: not taken
    send_item(KIND_ARB, 0, 0, 0, 0);          // every requesting row locked
  endtask

  task automatic test_clear();
    send_item(KIND_CLR, 0, 0, 3, 3);          // wrong winner
    send_item(KIND_CLR, 1, 1, 0, 0);          // no winner
    send_item(KIND_CLR, 0, 0, 4, 1);          // round robin picked port 4, vc 1
    send_item(KIND_CLR, 4, 3, 2, 2);
    send_item(KIND_ARB, 0, 0, 0, 0);
  endtask

  task automatic test_squash();
    send_item(KIND_REQ, 2, 0, 3, 1);
    send_item(KIND_REQ, 2, 1, 3, 1);
    send_item(KIND_REQ, 3, 2, 3, 1);
    send_item(KIND_ARB, 0, 0, 0, 0);
    send_item(KIND_SQ, 2, 0, 3, 1);
    send_item(KIND_QRY, 3, 2, 3, 1);
  endtask

  task automatic test_out_of_range();
    send_item(KIND_REQ, 5, 0, 0, 0);
    send_item(KIND_REQ, 0, 0, 7, 3);
    send_item(KIND_QRY, 6, 3, 0, 0);
    send_item(KIND_CLR, 7, 3, 5, 2);
    send_item(KIND_SQ, 7, 2, 6, 1);
    send_item(KIND_SQ, 6, 0, 0, 0);
    for (int k = 5; k < 8; k++) send_item(3'(k), 3'd7, 2'd3, 3'd7, 2'd3);
  endtask

  task automatic test_random_traffic(int count);
    int roll, o, w;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 35)
        send_item(KIND_REQ, 3'($urandom_range(0, PORTS - 1)), 2'($urandom),
                  3'($urandom_range(0, PORTS - 1)), 2'($urandom));
      else if (roll < 47)
        send_item(KIND_ARB, 3'($urandom), 2'($urandom), 3'($urandom), 2'($urandom));
      else if (roll < 67) begin
        if (choose_locked_vc(o, w))
          send_item(KIND_CLR, 3'(o / VCS), 2'(o % VCS), 3'(w / VCS), 2'(w % VCS));
        else send_random_noise();
      end else if (roll < 77) begin
        if (choose_locked_vc(o, w))
          send_item(KIND_SQ, ($urandom_range(0, 1) ? 3'(o / VCS)
                                                   : 3'($urandom_range(0, PORTS - 1))),
                    2'($urandom), 3'(w / VCS), 2'(w % VCS));
        else send_random_noise();
      end else if (roll < 87)
        send_item(KIND_QRY, 3'($urandom_range(0, PORTS - 1)), 2'($urandom),
                  3'($urandom_range(0, PORTS - 1)), 2'($urandom));
      else
        send_random_noise();
    end
    steady = 0;
  endtask

  // result side backpressure
  initial begin
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if (!steady && $urandom_range(0, 4) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    result_t exp_r;
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{accepted_o, error_o, grant_valid_o, grant_out_port_o, grant_out_vc_o,
              grant_in_port_o, grant_in_vc_o, last_o};
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        mismatch_count++;
      end else begin
        exp_r = expected_beats.pop_front();
        if (got.acc !== exp_r.acc || got.err !== exp_r.err || got.gv !== exp_r.gv ||
            got.gop !== exp_r.gop || got.gov !== exp_r.gov || got.gip !== exp_r.gip ||
            got.giv !== exp_r.giv || got.last !== exp_r.last) begin
          $display("%0t: expected acc=%b err=%b gv=%b go=%0d.%0d gi=%0d.%0d last=%b",
                   $time, exp_r.acc, exp_r.err, exp_r.gv, exp_r.gop, exp_r.gov,
                   exp_r.gip, exp_r.giv, exp_r.last);
          $display("%0t: actual   acc=%b err=%b gv=%b go=%0d.%0d gi=%0d.%0d last=%b",
                   $time, got.acc, got.err, got.gv, got.gop, got.gov,
                   got.gip, got.giv, got.last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NOVC; i++) begin
      req_bits[i] = '0; locked[i] = 0; win_valid[i] = 0; win_index[i] = 0;
      port_ptr[i] = 0;
      for (int p = 0; p < PORTS; p++) vc_ptr[i][p] = 0;
    end
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = '0; out_port_i = '0; out_vc_i = '0; in_port_i = '0; in_vc_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_requests_and_grants();
    test_clear();
    test_squash();
    test_out_of_range();
    test_random_traffic(170);
    wait_drained();
    repeat (40) @(negedge clk_i);

    if (mismatch_count == 0 && expected_beats.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
